>>> sv/tcptg_pkg.sv
// shared types, widths and helpers for the two-channel pulse tone generator
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package tcptg_pkg;

  localparam int STEP_W = 32;
  localparam int PER_W  = 16;
  localparam int VOL_W  = 9;
  localparam int LEN_W  = 24;
  localparam int SAMP_W = 17;
  localparam int BIT_W  = $clog2(STEP_W);

  localparam logic [VOL_W-1:0] VOL_ONE = VOL_W'(256);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CMP,
    ST_WRITE
  } state_t;

  // volumes above 1.0 clamp to 1.0
  function automatic logic [VOL_W-1:0] sat_vol(input logic [VOL_W-1:0] v);
    return (v > VOL_ONE) ? VOL_ONE : v;
  endfunction

endpackage

`default_nettype wire

>>> sv/tcptg_in_if.sv
// input channel: tick or note load items with valid/ready
// depends on tcptg_pkg for field widths
`default_nettype none

interface tcptg_in_if import tcptg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic             channel;
  logic [PER_W-1:0] period_samples;
  logic [PER_W-1:0] high_samples;
  logic [VOL_W-1:0] note_volume;
  logic [LEN_W-1:0] note_length;

  modport source (
    output valid, op, channel, period_samples, high_samples, note_volume, note_length,
    input  ready
  );
  modport sink (
    input  valid, op, channel, period_samples, high_samples, note_volume, note_length,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/tcptg_out_if.sv
// result channel: one stereo sample pair per tick with valid/ready
// depends on tcptg_pkg for field widths
`default_nettype none

interface tcptg_out_if import tcptg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SAMP_W-1:0] left_sample;
  logic [SAMP_W-1:0] right_sample;

  modport source (
    output valid, left_sample, right_sample,
    input  ready
  );
  modport sink (
    input  valid, left_sample, right_sample,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/tcptg_cfg_if.sv
// configuration write channel carrying the master volume
// depends on tcptg_pkg for the volume width
`default_nettype none

interface tcptg_cfg_if import tcptg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VOL_W-1:0] master_volume;

  modport source (
    output valid, master_volume,
    input  ready
  );
  modport sink (
    input  valid, master_volume,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/two_channel_pulse_tone_generator.sv
// top level: two pulse channels with length counters and a shared modulo unit
// depends on tcptg_pkg and the tcptg_in_if, tcptg_out_if, tcptg_cfg_if interfaces
`default_nettype none

// A load item updates one channel and gives no result. A tick item holds the block busy:
// after the accept cycle, each channel in turn goes through the one shared 16-bit
// restoring remainder unit in ST_DIV (one bit of the sample step per cycle), then is
// compared against the duty length and scaled by the volumes in ST_CMP;
// then ST_WRITE loads the output register, which is held off
// for as long as the previous pair is still waiting there. The stereo pair sits in
// that output register until transferred, so a following load is taken and a
// following tick runs its arithmetic while the previous pair waits. Master volume
// writes are taken at any cycle; volumes above 1.0 are clamped when written.
module two_channel_pulse_tone_generator import tcptg_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  tcptg_in_if.sink     in_ch,
  tcptg_out_if.source  out_ch,
  tcptg_cfg_if.sink    cfg_ch
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PER_W-1:0]  per_r    [2];
  logic [PER_W-1:0]  per_nxt  [2];
  logic [PER_W-1:0]  high_r   [2];
  logic [PER_W-1:0]  high_nxt [2];
  logic [VOL_W-1:0]  vol_r    [2];
  logic [VOL_W-1:0]  vol_nxt  [2];
  logic [LEN_W-1:0]  len_r    [2];
  logic [LEN_W-1:0]  len_nxt  [2];
  logic [VOL_W-1:0]  master_r, master_nxt;

  logic [PER_W-1:0]  rem_r, rem_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              ch_r, ch_nxt;
  logic [SAMP_W-1:0] samp_r   [2];
  logic [SAMP_W-1:0] samp_nxt [2];

  logic              out_valid_r, out_valid_nxt;
  logic [SAMP_W-1:0] out_left_r, out_left_nxt;
  logic [SAMP_W-1:0] out_right_r, out_right_nxt;

  logic [PER_W-1:0]   cur_per;
  logic [PER_W:0]     trial;
  logic [PER_W:0]     diff;
  logic               fits;
  logic [2*VOL_W-1:0] prod;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.left_sample  = out_left_r;
  assign out_ch.right_sample = out_right_r;

  // shared remainder unit: shift in one step bit, subtract the cycle length if it fits
  assign cur_per = per_r[ch_r];
  assign trial   = {rem_r, step_r[bit_r]};
  assign diff    = trial - {1'b0, cur_per};
  assign fits    = (trial >= {1'b0, cur_per});
  assign prod    = vol_r[ch_r] * master_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    per_nxt       = per_r;
    high_nxt      = high_r;
    vol_nxt       = vol_r;
    len_nxt       = len_r;
    master_nxt    = master_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    ch_nxt        = ch_r;
    samp_nxt      = samp_r;
    out_valid_nxt = out_valid_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;

    if (cfg_ch.valid) begin
      master_nxt = sat_vol(cfg_ch.master_volume);
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.op == OP_LOAD) begin
            per_nxt[in_ch.channel]  = in_ch.period_samples;
            high_nxt[in_ch.channel] = in_ch.high_samples;
            vol_nxt[in_ch.channel]  = sat_vol(in_ch.note_volume);
            len_nxt[in_ch.channel]  = in_ch.note_length;
          end else begin
            step_nxt = step_r + 1'b1;
            for (int i = 0; i < 2; i++) begin
              // the tick that reaches zero is already silent
              if (len_r[i] <= LEN_W'(1)) begin
                len_nxt[i] = '0;
                vol_nxt[i] = '0;
              end else begin
                len_nxt[i] = len_r[i] - 1'b1;
              end
            end
            rem_nxt   = '0;
            bit_nxt   = BIT_W'(STEP_W - 1);
            ch_nxt    = 1'b0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = fits ? diff[PER_W-1:0] : trial[PER_W-1:0];
        if (bit_r == '0) begin
          state_nxt = ST_CMP;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      ST_CMP: begin
        // a zero cycle length means silence
        if ((cur_per != '0) && (rem_r <= high_r[ch_r])) begin
          samp_nxt[ch_r] = prod[SAMP_W-1:0];
        end else begin
          samp_nxt[ch_r] = '0;
        end
        if (ch_r == 1'b0) begin
          ch_nxt    = 1'b1;
          rem_nxt   = '0;
          bit_nxt   = BIT_W'(STEP_W - 1);
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = samp_r[0];
          out_right_nxt = samp_r[1];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      per_r       <= '{default: '0};
      high_r      <= '{default: '0};
      vol_r       <= '{default: '0};
      len_r       <= '{default: '0};
      master_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      per_r       <= per_nxt;
      high_r      <= high_nxt;
      vol_r       <= vol_nxt;
      len_r       <= len_nxt;
      master_r    <= master_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    ch_r        <= ch_nxt;
    samp_r      <= samp_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

`ifndef NO_ASSERTIONS
  // an accepted tick always starts the remainder sequence
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && (in_ch.op == OP_TICK) |=> state_r == ST_DIV)
    else $error("tick transfer did not start the remainder sequence");

  // clamped volumes keep every sample at or below 1.0
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_left_r <= SAMP_W'(65536)) && (out_right_r <= SAMP_W'(65536)))
    else $error("output sample above full scale");

  // a transferred pair is not shown again unless a new one is written
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.ready && (state_r != ST_WRITE) |=> !out_valid_r)
    else $error("output pair repeated after transfer");

  // remainder stays below a nonzero cycle length
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) && (cur_per != '0) |-> rem_r < cur_per)
    else $error("remainder not reduced below cycle length");
`endif

endmodule

`default_nettype wire

>>> verif/tb.sv
// testbench for two_channel_pulse_tone_generator: directed notes, a master volume sweep
// and random note/tick traffic, each sample pair checked against a cycle-free predictor
// depends on tcptg_pkg and the tcptg_in_if, tcptg_out_if, tcptg_cfg_if interfaces
`default_nettype none

module tb import tcptg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  // a tick keeps the block busy through its remainder and compare steps; add both sides' longest waits and margin
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int LOAD_SETTLE = 8;
  localparam int MAX_WAIT = 18;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 120;

  typedef struct packed {
    logic             op;
    logic             channel;
    logic [PER_W-1:0] period_samples;
    logic [PER_W-1:0] high_samples;
    logic [VOL_W-1:0] note_volume;
    logic [LEN_W-1:0] note_length;
  } tone_item_t;

  typedef struct packed {
    logic [SAMP_W-1:0] left;
    logic [SAMP_W-1:0] right;
  } sample_pair_t;

  logic clk;
  logic rst_n;

  tcptg_in_if  in_ch ();
  tcptg_out_if out_ch ();
  tcptg_cfg_if cfg_ch ();

  two_channel_pulse_tone_generator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // tone state as the block should hold it
  logic [STEP_W-1:0] step_now;
  logic [PER_W-1:0]  ch_period [2];
  logic [PER_W-1:0]  ch_high   [2];
  logic [VOL_W-1:0]  ch_vol    [2];
  logic [LEN_W-1:0]  ch_remain [2];
  logic [VOL_W-1:0]  gain_master;

  sample_pair_t expected_pairs [$];

  int unsigned fail_count;
  int unsigned n_items;
  int unsigned n_ticks;
  int unsigned n_loads;
  int unsigned n_pairs;
  int unsigned n_cfg;
  int unsigned idle_cycles;
  bit          in_calm;
  bit          out_calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [VOL_W-1:0] clamp_gain(input logic [VOL_W-1:0] v);
    return (v > VOL_ONE) ? VOL_ONE : v;
  endfunction

  function automatic logic [SAMP_W-1:0] pulse_level(input int ch);
    logic [PER_W-1:0]     phase;
    logic [2*VOL_W-1:0]   prod;
    if (ch_period[ch] == '0) return '0;
    phase = PER_W'(step_now % ch_period[ch]);
    prod = ch_vol[ch] * gain_master;
    return (phase <= ch_high[ch]) ? prod[SAMP_W-1:0] : '0;
  endfunction

  // advance the tone state by one accepted item, queue the sample pair of a tick
  task automatic apply_item(input tone_item_t it);
    sample_pair_t pair;
    int           i;
    n_items++;
    if (it.op == OP_LOAD) begin
      n_loads++;
      ch_period[it.channel] = it.period_samples;
      ch_high[it.channel]   = it.high_samples;
      ch_vol[it.channel]    = clamp_gain(it.note_volume);
      ch_remain[it.channel] = it.note_length;
    end else begin
      n_ticks++;
      step_now = step_now + 1'b1;
      for (i = 0; i < 2; i++) begin
        if (ch_remain[i] <= 1) begin
          ch_remain[i] = '0;
          ch_vol[i]    = '0;
        end else begin
          ch_remain[i] = ch_remain[i] - 1'b1;
        end
      end
      pair.left  = pulse_level(0);
      pair.right = pulse_level(1);
      expected_pairs.push_back(pair);
    end
  endtask

  // long stretches without waits come from flipping into a calm mode now and then
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic note_mismatch(input string what, input int unsigned exp_v,
                               input int unsigned got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_v, got_v);
  endtask

  // called at a rising edge; returns at a rising edge with valid possibly still high
  task automatic send_item(input tone_item_t it);
    int unsigned gap;
    in_ch.valid          <= 1'b1;
    in_ch.op             <= it.op;
    in_ch.channel        <= it.channel;
    in_ch.period_samples <= it.period_samples;
    in_ch.high_samples   <= it.high_samples;
    in_ch.note_volume    <= it.note_volume;
    in_ch.note_length    <= it.note_length;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(it);
    gap = draw_wait(in_calm);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic quiet_input();
    in_ch.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    // a load leaves no result behind, so give it time to land
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic write_master(input logic [VOL_W-1:0] v);
    quiet_input();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.master_volume <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    gain_master = clamp_gain(v);
    n_cfg++;
  endtask

  function automatic tone_item_t make_note(input logic ch, input logic [PER_W-1:0] per,
                                           input logic [PER_W-1:0] high,
                                           input logic [VOL_W-1:0] vol,
                                           input logic [LEN_W-1:0] len);
    tone_item_t it;
    it.op             = OP_LOAD;
    it.channel        = ch;
    it.period_samples = per;
    it.high_samples   = high;
    it.note_volume    = vol;
    it.note_length    = len;
    return it;
  endfunction

  function automatic tone_item_t plain_tick();
    tone_item_t it;
    it    = '0;
    it.op = OP_TICK;
    return it;
  endfunction

  function automatic tone_item_t random_item();
    tone_item_t  it;
    int unsigned pick;
    it.op      = ($urandom_range(0, 9) < 6) ? OP_TICK : OP_LOAD;
    it.channel = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 6)      it.period_samples = PER_W'($urandom_range(0, 12));
    else if (pick < 8) it.period_samples = PER_W'($urandom_range(13, 300));
    else               it.period_samples = PER_W'($urandom());
    if ($urandom_range(0, 9) < 7)
      it.high_samples = PER_W'($urandom_range(0, it.period_samples + 1));
    else
      it.high_samples = PER_W'($urandom());
    it.note_volume = VOL_W'($urandom_range(0, 511));
    pick = $urandom_range(0, 9);
    if (pick < 6)      it.note_length = LEN_W'($urandom_range(0, 40));
    else if (pick < 8) it.note_length = LEN_W'($urandom_range(41, 2000));
    else if (pick < 9) it.note_length = LEN_W'($urandom());
    else               it.note_length = '1;
    return it;
  endfunction

  task automatic test_reset_and_notes();
    tone_item_t loud_tick;
    loud_tick         = '1;
    loud_tick.op      = OP_TICK;
    // reset state: silent, master volume zero
    send_item(plain_tick());
    write_master(VOL_ONE);
    send_item(make_note(CH_LEFT, 16'd4, 16'd1, 9'd256, 24'd3));
    // zero cycle stays silent even at full volume
    send_item(make_note(CH_RIGHT, 16'd0, 16'hFFFF, 9'd511, 24'hFFFFFF));
    repeat (3) send_item(plain_tick());
    // a length of one is already muted on the next tick
    send_item(make_note(CH_LEFT, 16'd1, 16'd0, 9'd1, 24'd1));
    send_item(make_note(CH_RIGHT, 16'hFFFF, 16'hFFFF, 9'd300, 24'hFFFFFF));
    send_item(plain_tick());
    send_item(make_note(CH_LEFT, 16'd3, 16'd0, 9'd128, 24'd0));
    send_item(plain_tick());
    send_item(make_note(CH_LEFT, 16'd2, 16'd0, 9'd257, 24'd2));
    send_item(make_note(CH_RIGHT, 16'hFFFF, 16'd0, 9'd255, 24'd2));
    repeat (3) send_item(plain_tick());
    // tick with every unused field set must behave like a plain tick
    send_item(loud_tick);
    send_item(make_note(CH_RIGHT, 16'd1, 16'd0, 9'd256, 24'hFFFFFF));
    send_item(make_note(CH_LEFT, 16'd5, 16'd4, 9'd0, 24'd10));
    repeat (2) send_item(plain_tick());
  endtask

  task automatic test_master_volume_sweep();
    logic [VOL_W-1:0] levels [6];
    int               k;
    levels = '{9'd0, 9'd1, 9'd255, 9'd256, 9'd257, 9'd511};
    for (k = 0; k < 6; k++) begin
      write_master(levels[k]);
      send_item(make_note(CH_LEFT, 16'd1, 16'd0, 9'd256, 24'hFFFFFF));
      send_item(make_note(CH_RIGHT, 16'd2, 16'd0, VOL_W'($urandom_range(0, 511)),
                          24'hFFFFFF));
      repeat (3) send_item(plain_tick());
    end
  endtask

  task automatic test_random_notes();
    int p;
    int j;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          write_master(VOL_ONE);
        end
        1: begin
          write_master(9'd511);
        end
        2: begin
          write_master(9'd0);
        end
        3: begin
          write_master(9'd1);
        end
        default: begin
          write_master(VOL_W'($urandom_range(0, 511)));
        end
      endcase
      for (j = 0; j < PHASE_ITEMS; j++) send_item(random_item());
    end
  endtask

  // result side: random stalls, one draw per transfer
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(out_calm);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    sample_pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pairs.size() == 0) begin
        note_mismatch("unexpected transfer, left_sample", 0, out_ch.left_sample);
      end else begin
        want = expected_pairs.pop_front();
        n_pairs++;
        if (out_ch.left_sample !== want.left)
          note_mismatch("left_sample", want.left, out_ch.left_sample);
        if (out_ch.right_sample !== want.right)
          note_mismatch("right_sample", want.right, out_ch.right_sample);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d sample pairs outstanding",
               $realtime, STALL_LIMIT, expected_pairs.size());
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    fail_count  = 0;
    n_items     = 0;
    n_ticks     = 0;
    n_loads     = 0;
    n_pairs     = 0;
    n_cfg       = 0;
    idle_cycles = 0;
    in_calm     = 1'b0;
    out_calm    = 1'b0;
    step_now    = '0;
    gain_master = '0;
    for (i = 0; i < 2; i++) begin
      ch_period[i] = '0;
      ch_high[i]   = '0;
      ch_vol[i]    = '0;
      ch_remain[i] = '0;
    end

    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.op             <= OP_TICK;
    in_ch.channel        <= CH_LEFT;
    in_ch.period_samples <= '0;
    in_ch.high_samples   <= '0;
    in_ch.note_volume    <= '0;
    in_ch.note_length    <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.master_volume <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_and_notes();
    test_master_volume_sweep();
    test_random_notes();

    in_ch.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d items sent (%0d ticks, %0d note loads), %0d master volume writes",
             n_items, n_ticks, n_loads, n_cfg);
    $display("tb: %0d sample pairs compared, %0d failures", n_pairs, fail_count);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
